// File: design/kpsd_pkg.sv
package kpsd_pkg;

  // Event ring geometry.
  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // Key and register widths.
  localparam int KEY_COUNT = 16;
  localparam int KEY_W     = 4;
  localparam int LIMIT_W   = 4;
  localparam int CODE_W    = 8;
  localparam int CNT_W     = PTR_W + 4;

  // Configuration register indexes.
  localparam logic REG_DEBOUNCE_LIMIT = 1'b0;
  localparam logic REG_PRESSED_LEVEL  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = LIMIT_W'(2);
  localparam logic               PRESSED_LEVEL_RST  = 1'b0;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [KEY_W-1:0] key_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch a new item and clear the event fields
    logic scan_step;  // debounce one key and advance the key counter
    logic pop_rd;     // read the ring entry at the head
    logic pop_load;   // capture the popped event and advance the head
    logic out_load;   // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_key;
    logic ring_empty;
    logic out_free;
  } stat_t;

  // Advance a ring pointer with wrap-around.
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  // Number of events held between head and tail.
  function automatic logic [CNT_W-1:0] ring_count(input ptr_t head, input ptr_t tail);
    logic [CNT_W-1:0] h;
    logic [CNT_W-1:0] t;
    logic [CNT_W-1:0] r;
    h = CNT_W'(head);
    t = CNT_W'(tail);
    if (t >= h) begin
      r = t - h;
    end else begin
      r = t + CNT_W'(RING_DEPTH) - h;
    end
    return r;
  endfunction

  // Fixed key map, indexed by row*4+col.
  function automatic logic [CODE_W-1:0] key_ascii(input key_t k);
    logic [CODE_W-1:0] c;
    unique case (k)
      4'd0:    c = "1";
      4'd1:    c = "4";
      4'd2:    c = "7";
      4'd3:    c = "*";
      4'd4:    c = "2";
      4'd5:    c = "5";
      4'd6:    c = "8";
      4'd7:    c = "0";
      4'd8:    c = "3";
      4'd9:    c = "6";
      4'd10:   c = "9";
      4'd11:   c = "#";
      4'd12:   c = "A";
      4'd13:   c = "B";
      4'd14:   c = "C";
      default: c = "D";
    endcase
    return c;
  endfunction

endpackage

// File: design/kpsd_ram.sv
module kpsd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/kpsd_ctrl.sv
module kpsd_ctrl
  import kpsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  logic  in_tuser,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN     = 5'b00010,
    ST_POP_RD   = 5'b00100,
    ST_POP_DATA = 5'b01000,
    ST_WRITE    = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Sequencing of scan and pop items.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (!in_tuser) begin
            state_nxt = ST_SCAN;
          end else if (stat.ring_empty) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_POP_RD;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.last_key) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = ST_POP_DATA;
      end
      ST_POP_DATA: begin
        cmd.pop_load = 1'b1;
        state_nxt    = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/kpsd_dp.sv
module kpsd_dp
  import kpsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          in_tdata,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [LIMIT_W-1:0]   cfg_wdata,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tuser
);

  // Configuration registers.
  logic [LIMIT_W-1:0] limit_r;
  logic               press_lvl_r;

  // Debounce state per key.
  logic [KEY_COUNT-1:0] last_r;
  logic [KEY_COUNT-1:0] stable_r;
  logic [LIMIT_W-1:0]   cnt_r [KEY_COUNT];

  // Item and scan sequencing.
  logic [15:0]      levels_r;
  logic [KEY_W-1:0] step_r;

  // Ring pointers.
  ptr_t head_r;
  ptr_t tail_r;

  // Event fields of the result under construction.
  logic              ev_valid_r;
  logic [CODE_W-1:0] ev_code_r;
  logic [1:0]        ev_row_r;
  logic [1:0]        ev_col_r;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_user_r;

  // Per-key step signals.
  key_t             key;
  logic             hit;
  logic [LIMIT_W-1:0] cnt_cur;
  logic [LIMIT_W-1:0] cnt_inc;
  logic             changed;
  logic             counting;
  logic             settle;
  logic             push;
  ptr_t             tail_inc;
  logic [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0] count_full;

  // Column-major walk: the counter's low bits pick the row, high bits the column.
  assign key      = {step_r[1:0], step_r[3:2]};
  assign hit      = (levels_r[key] == press_lvl_r);
  assign cnt_cur  = cnt_r[key];
  assign cnt_inc  = cnt_cur + LIMIT_W'(1);
  assign changed  = (hit != last_r[key]);
  assign counting = !changed && (cnt_cur < limit_r);
  assign settle   = counting && (cnt_inc == limit_r) && (hit != stable_r[key]);
  assign push     = cmd.scan_step && settle && hit;
  assign tail_inc = ptr_inc(tail_r);

  // Event storage.
  kpsd_ram #(
    .WIDTH (KEY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push),
    .waddr (tail_r),
    .wdata (key),
    .re    (cmd.pop_rd),
    .raddr (head_r),
    .rdata (rd_key)
  );

  assign count_full = ring_count(head_r, tail_r);

  // Status for the controller.
  assign stat.last_key   = (step_r == KEY_W'(KEY_COUNT - 1));
  assign stat.ring_empty = (head_r == tail_r);
  assign stat.out_free   = !out_valid_r || out_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= DEBOUNCE_LIMIT_RST;
      press_lvl_r <= PRESSED_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE_LIMIT: limit_r     <= cfg_wdata;
        REG_PRESSED_LEVEL:  press_lvl_r <= cfg_wdata[0];
        default:            ;
      endcase
    end
  end

  // Debounce update of the key at the current scan step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      stable_r <= '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.scan_step) begin
      if (changed) begin
        last_r[key] <= hit;
        cnt_r[key]  <= '0;
      end else if (counting) begin
        cnt_r[key] <= cnt_inc;
        if (settle) begin
          stable_r[key] <= hit;
        end
      end
    end
  end

  // Scan step counter and latched pin levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.accept) begin
      step_r <= '0;
    end else if (cmd.scan_step) begin
      step_r <= step_r + KEY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      levels_r <= in_tdata;
    end
  end

  // Ring pointers: a push into a full ring drops the oldest event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else if (push) begin
      tail_r <= tail_inc;
      if (tail_inc == head_r) begin
        head_r <= ptr_inc(head_r);
      end
    end else if (cmd.pop_load) begin
      head_r <= ptr_inc(head_r);
    end
  end

  // Event fields: cleared on every new item, filled by a pop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (cmd.accept) begin
      ev_valid_r <= 1'b0;
    end else if (cmd.pop_load) begin
      ev_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ev_code_r <= '0;
      ev_row_r  <= '0;
      ev_col_r  <= '0;
    end else if (cmd.pop_load) begin
      ev_code_r <= key_ascii(rd_key);
      ev_row_r  <= rd_key[3:2];
      ev_col_r  <= rd_key[1:0];
    end
  end

  // Output register; the pending count is taken after the item's ring update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_user_r <= ev_valid_r;
      out_data_r <= {count_full[3:0], ev_col_r, ev_row_r, ev_code_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: design/keypad_scan_debounce_event_fifo.sv
// 4x4 keypad scanner with per-key counter debounce and a 16-slot key-event ring.
// An input item with in_tuser low is a scan: in_tdata carries one pin level per key
// at bit row*4+col, and the keys are debounced one per cycle in column-major order;
// after the last key the result is loaded into the output register once that is free,
// and the next item is accepted in the cycle after the load. An item with in_tuser
// high pops the oldest event: a registered read of the event memory, a capture of
// the popped event, then the output load; when the ring is empty it goes straight
// to the output load. Every item gives exactly one result. A new item is accepted
// while the previous result still waits in the output register. The ring keeps at
// most 15 events and a press into a full ring drops the oldest one. The user must
// make configuration writes only while the block is idle; the block itself does
// not enforce this.
module keypad_scan_debounce_event_fifo
  import kpsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // pin_levels[15:0]
  input  logic               in_tuser,   // action
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // key_code[7:0], key_row[9:8], key_col[11:10],
                                         // pending_events[15:12]
  output logic               out_tuser,  // event_valid
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // Controller: sequences scans and pops.
  kpsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: debounce state, event ring and output register.
  kpsd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
